// ===== rtl/line_follow_pid_controller_defines.svh =====
// Assertion macros for the line-follow PID controller.
// Used by the top level; the using scope provides clk and arst_n.
`ifndef LINE_FOLLOW_PID_CONTROLLER_DEFINES_SVH
`define LINE_FOLLOW_PID_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LFPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfpc assertion failed");
// next-cycle implication
`define LFPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfpc assertion failed");
`else
`define LFPC_ASSERT_IMP(label, ante, cons)
`define LFPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/lfpc_pkg.sv =====
// Shared types and constants of the line-follow PID controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lfpc_pkg;

	// field and state widths
	localparam int SAMPLE_W   = 12;
	localparam int MAX_WINDOW = 1024;
	localparam int WIN_W      = 11;
	localparam int TOTAL_W    = 22;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int PERIOD_W   = 16;
	localparam int INTEG_W    = 32;
	localparam int CORR_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// serial units: one quotient bit / one gain bit per cycle
	localparam int DIV_STEPS  = TOTAL_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int MCAND_W    = 32;
	localparam int MUL_STEPS  = GAIN_W;
	localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
	localparam int PROD_W     = MCAND_W + GAIN_W;

	// register reset values
	localparam logic [SAMPLE_W-1:0] THR_RESET    = 12'd2048;
	localparam logic [WIN_W-1:0]    SPU_RESET    = 11'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd66;
	localparam logic [PERIOD_W-1:0] RATE_RESET   = 16'd1000;

	// line error codes
	localparam logic signed [1:0] ERR_ZERO  = 2'sb00;
	localparam logic signed [1:0] ERR_LEFT  = 2'sb01;
	localparam logic signed [1:0] ERR_RIGHT = 2'sb11;

	typedef enum logic [2:0] {
		REG_KP     = 3'd0,
		REG_KI     = 3'd1,
		REG_KD     = 3'd2,
		REG_LIMIT  = 3'd3,
		REG_THR    = 3'd4,
		REG_SPU    = 3'd5,
		REG_PERIOD = 3'd6,
		REG_RATE   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic [LIMIT_W-1:0]       limit;
		logic [SAMPLE_W-1:0]      thr;
		logic [WIN_W-1:0]         spu;
		logic [PERIOD_W-1:0]      period;
		logic [PERIOD_W-1:0]      rate;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LINE,
		ST_INTEG,
		ST_MUL_GO,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/line_follow_pid_controller.sv =====
// Top level of the line-follow PID controller: window sums, sequencer, PID step.
// Depends on lfpc_pkg, lfpc_regs, lfpc_div, lfpc_mul and the defines header.
//
//  channel  | handshake              | word
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_stall    | op, left_sample, right_sample
//  out      | out_valid / out_stall  | averages, on-tape flags, line_error,
//           |                        | correction
//  cfg      | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// A clear word or a tick inside the window leaves the sequencer idle, ready for the next word.
// A tick that closes the window holds off the next word while it runs the
// bit-serial dividers (one quotient bit each), then the serial multipliers
// (one gain bit each), plus the sequencing steps.
// Reset clears the window, held error, integral and previous error.
// A stalled result holds the sequencer in its last step; in_stall stays high
// from a window end until the result sits in the output register.
`timescale 1ns / 1ps
`include "line_follow_pid_controller_defines.svh"

module line_follow_pid_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [lfpc_pkg::ADDR_W-1:0]            paddr,
	input  logic [lfpc_pkg::DATA_W-1:0]            pwdata,
	output logic [lfpc_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   op,
	input  logic [lfpc_pkg::SAMPLE_W-1:0]          left_sample,
	input  logic [lfpc_pkg::SAMPLE_W-1:0]          right_sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [lfpc_pkg::SAMPLE_W-1:0]          left_average,
	output logic [lfpc_pkg::SAMPLE_W-1:0]          right_average,
	output logic                                   left_on_tape,
	output logic                                   right_on_tape,
	output logic signed [1:0]                      line_error,
	output logic signed [lfpc_pkg::CORR_W-1:0]     correction
);

	localparam int SUM_W = 36;
	localparam int ACC_W = lfpc_pkg::INTEG_W + 2;
	localparam int DER_W = lfpc_pkg::PERIOD_W + 2;
	localparam logic [lfpc_pkg::WIN_W-1:0] WIN_MAX = lfpc_pkg::WIN_W'(lfpc_pkg::MAX_WINDOW);
	localparam logic signed [SUM_W-1:0] CORR_MAX = SUM_W'({1'b0, {(lfpc_pkg::CORR_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] CORR_MIN = -CORR_MAX - SUM_W'(1);

	lfpc_pkg::cfg_t   cfg;
	lfpc_pkg::state_t state_q, state_d;

	// window and controller state
	logic [lfpc_pkg::TOTAL_W-1:0]        total_l_q, total_r_q;
	logic [lfpc_pkg::WIN_W-1:0]          count_q;
	logic signed [1:0]                   held_q, prev_q;
	logic signed [lfpc_pkg::INTEG_W-1:0] integral_q;

	// per-window working registers
	logic [lfpc_pkg::SAMPLE_W-1:0]       lavg_q, ravg_q;
	logic                                lon_q, ron_q;
	logic signed [1:0]                   err_q;
	logic signed [DER_W-1:0]             deriv_q;
	logic signed [SUM_W-1:0]             sum_q;
	logic                                out_valid_q;

	logic [lfpc_pkg::TOTAL_W-1:0]        sum_l, sum_r, quo_l, quo_r;
	logic [lfpc_pkg::WIN_W-1:0]          count_next, n_eff;
	logic                                win_end, accept;
	logic                                div_start, div_done, div_done_l, div_done_r;
	logic                                mul_start, mul_done, mul_done_i, mul_done_d;
	logic                                out_load;
	logic signed [lfpc_pkg::PROD_W-1:0]  prod_i, prod_d;
	logic                                lon, ron;
	logic signed [1:0]                   err;
	logic signed [ACC_W-1:0]             acc, lim_ext, lim_neg, int_ext, step;
	logic signed [2:0]                   err_diff;
	logic signed [DER_W-1:0]             rate_ext, deriv;
	logic signed [lfpc_pkg::GAIN_W:0]    kp_e;
	logic signed [lfpc_pkg::CORR_W-1:0]  corr_sat;

	lfpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// window length: zero acts as one, capped at the maximum window
	always_comb begin
		if (cfg.spu == '0) begin
			n_eff = lfpc_pkg::WIN_W'(1);
		end else if (cfg.spu > WIN_MAX) begin
			n_eff = WIN_MAX;
		end else begin
			n_eff = cfg.spu;
		end
	end

	assign sum_l      = total_l_q + lfpc_pkg::TOTAL_W'(left_sample);
	assign sum_r      = total_r_q + lfpc_pkg::TOTAL_W'(right_sample);
	assign count_next = count_q + 1'b1;
	assign win_end    = count_next >= n_eff;
	assign accept     = in_valid && !in_stall;

	lfpc_div u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_l),
		.divisor  (n_eff),
		.done     (div_done_l),
		.quotient (quo_l)
	);

	lfpc_div u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_r),
		.divisor  (n_eff),
		.done     (div_done_r),
		.quotient (quo_r)
	);

	assign div_done = div_done_l && div_done_r;

	// integral term and derivative term run side by side
	lfpc_mul u_mul_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (integral_q),
		.mplier  (cfg.ki),
		.done    (mul_done_i),
		.product (prod_i)
	);

	lfpc_mul u_mul_d (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (lfpc_pkg::MCAND_W'(deriv_q)),
		.mplier  (cfg.kd),
		.done    (mul_done_d),
		.product (prod_d)
	);

	assign mul_done = mul_done_i && mul_done_d;

	// tape flags and line error from the full quotients
	assign lon = quo_l > lfpc_pkg::TOTAL_W'(cfg.thr);
	assign ron = quo_r > lfpc_pkg::TOTAL_W'(cfg.thr);
	always_comb begin
		priority if (lon && ron) begin
			err = lfpc_pkg::ERR_ZERO;
		end else if (lon) begin
			err = lfpc_pkg::ERR_LEFT;
		end else if (ron) begin
			err = lfpc_pkg::ERR_RIGHT;
		end else begin
			err = held_q;
		end
	end

	// integral update with clamp
	assign int_ext = ACC_W'(integral_q);
	assign lim_ext = ACC_W'(cfg.limit);
	assign lim_neg = -lim_ext;
	always_comb begin
		unique case (err_q)
			lfpc_pkg::ERR_LEFT:  step = ACC_W'(cfg.period);
			lfpc_pkg::ERR_RIGHT: step = -ACC_W'(cfg.period);
			default:             step = '0;
		endcase
	end
	assign acc = int_ext + step;

	// derivative: change in error times rate, zero when the period is zero
	assign err_diff = 3'(err_q) - 3'(prev_q);
	assign rate_ext = DER_W'(cfg.rate);
	always_comb begin
		unique case (err_diff)
			3'sd1:   deriv = rate_ext;
			3'sd2:   deriv = rate_ext <<< 1;
			-3'sd1:  deriv = -rate_ext;
			-3'sd2:  deriv = -(rate_ext <<< 1);
			default: deriv = '0;
		endcase
	end

	// proportional term
	always_comb begin
		unique case (err_q)
			lfpc_pkg::ERR_LEFT:  kp_e = (lfpc_pkg::GAIN_W+1)'(cfg.kp);
			lfpc_pkg::ERR_RIGHT: kp_e = -(lfpc_pkg::GAIN_W+1)'(cfg.kp);
			default:             kp_e = '0;
		endcase
	end

	// saturate to 32 bits
	always_comb begin
		if (sum_q > CORR_MAX) begin
			corr_sat = CORR_MAX[lfpc_pkg::CORR_W-1:0];
		end else if (sum_q < CORR_MIN) begin
			corr_sat = CORR_MIN[lfpc_pkg::CORR_W-1:0];
		end else begin
			corr_sat = sum_q[lfpc_pkg::CORR_W-1:0];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			lfpc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && !op && win_end) begin
					div_start = 1'b1;
					state_d   = lfpc_pkg::ST_DIV;
				end
			end
			lfpc_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = lfpc_pkg::ST_LINE;
				end
			end
			lfpc_pkg::ST_LINE:  state_d = lfpc_pkg::ST_INTEG;
			lfpc_pkg::ST_INTEG: state_d = lfpc_pkg::ST_MUL_GO;
			lfpc_pkg::ST_MUL_GO: begin
				mul_start = 1'b1;
				state_d   = lfpc_pkg::ST_MUL;
			end
			lfpc_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d = lfpc_pkg::ST_SUM;
				end
			end
			lfpc_pkg::ST_SUM:   state_d = lfpc_pkg::ST_OUT;
			lfpc_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = lfpc_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// window sums and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_l_q  <= '0;
			total_r_q  <= '0;
			count_q    <= '0;
			held_q     <= lfpc_pkg::ERR_ZERO;
			prev_q     <= lfpc_pkg::ERR_ZERO;
			integral_q <= '0;
		end else begin
			if (accept && op) begin
				integral_q <= '0;
				prev_q     <= lfpc_pkg::ERR_ZERO;
			end else if (accept && win_end) begin
				total_l_q <= '0;
				total_r_q <= '0;
				count_q   <= '0;
			end else if (accept) begin
				total_l_q <= sum_l;
				total_r_q <= sum_r;
				count_q   <= count_next;
			end
			if ((state_q == lfpc_pkg::ST_LINE) && (lon || ron)) begin
				held_q <= err;
			end
			if (state_q == lfpc_pkg::ST_INTEG) begin
				if (acc > lim_ext) begin
					integral_q <= lim_ext[lfpc_pkg::INTEG_W-1:0];
				end else if (acc < lim_neg) begin
					integral_q <= lim_neg[lfpc_pkg::INTEG_W-1:0];
				end else begin
					integral_q <= acc[lfpc_pkg::INTEG_W-1:0];
				end
				prev_q <= err_q;
			end
		end
	end

	// per-window working registers
	always_ff @(posedge clk) begin
		if (state_q == lfpc_pkg::ST_LINE) begin
			lavg_q <= quo_l[lfpc_pkg::SAMPLE_W-1:0];
			ravg_q <= quo_r[lfpc_pkg::SAMPLE_W-1:0];
			lon_q  <= lon;
			ron_q  <= ron;
			err_q  <= err;
		end
		if (state_q == lfpc_pkg::ST_INTEG) begin
			deriv_q <= (cfg.period == '0) ? '0 : deriv;
		end
		if (state_q == lfpc_pkg::ST_SUM) begin
			sum_q <= SUM_W'(kp_e) + SUM_W'(signed'(prod_i[lfpc_pkg::PROD_W-1:16]))
				+ prod_d[SUM_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_average  <= lavg_q;
			right_average <= ravg_q;
			left_on_tape  <= lon_q;
			right_on_tape <= ron_q;
			line_error    <= err_q;
			correction    <= corr_sat;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`LFPC_ASSERT_NEXT(a_out_only_from_result, (!out_valid_q && (state_q != lfpc_pkg::ST_OUT)), !out_valid_q)
	`LFPC_ASSERT_IMP(a_div_done_in_div, (div_done_l || div_done_r), (state_q == lfpc_pkg::ST_DIV) && div_done)
	`LFPC_ASSERT_IMP(a_integral_in_limit, (state_q == lfpc_pkg::ST_MUL_GO), (int_ext <= lim_ext) && (int_ext >= lim_neg))
	`LFPC_ASSERT_NEXT(a_clear_zeroes, (accept && op), (integral_q == '0) && (prev_q == lfpc_pkg::ERR_ZERO))

endmodule

// ===== rtl/lfpc_regs.sv =====
// APB-style configuration registers of the line-follow PID controller.
// Depends on lfpc_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps

module lfpc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lfpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [lfpc_pkg::DATA_W-1:0]   pwdata,
	output logic [lfpc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output lfpc_pkg::cfg_t                cfg
);

	lfpc_pkg::cfg_idx_t idx;
	logic               wr_en;

	assign idx    = lfpc_pkg::cfg_idx_t'(paddr[lfpc_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.kp     <= '0;
			cfg.ki     <= '0;
			cfg.kd     <= '0;
			cfg.limit  <= '0;
			cfg.thr    <= lfpc_pkg::THR_RESET;
			cfg.spu    <= lfpc_pkg::SPU_RESET;
			cfg.period <= lfpc_pkg::PERIOD_RESET;
			cfg.rate   <= lfpc_pkg::RATE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				lfpc_pkg::REG_KP:     cfg.kp     <= pwdata[lfpc_pkg::GAIN_W-1:0];
				lfpc_pkg::REG_KI:     cfg.ki     <= pwdata[lfpc_pkg::GAIN_W-1:0];
				lfpc_pkg::REG_KD:     cfg.kd     <= pwdata[lfpc_pkg::GAIN_W-1:0];
				lfpc_pkg::REG_LIMIT:  cfg.limit  <= pwdata[lfpc_pkg::LIMIT_W-1:0];
				lfpc_pkg::REG_THR:    cfg.thr    <= pwdata[lfpc_pkg::SAMPLE_W-1:0];
				lfpc_pkg::REG_SPU:    cfg.spu    <= pwdata[lfpc_pkg::WIN_W-1:0];
				lfpc_pkg::REG_PERIOD: cfg.period <= pwdata[lfpc_pkg::PERIOD_W-1:0];
				lfpc_pkg::REG_RATE:   cfg.rate   <= pwdata[lfpc_pkg::PERIOD_W-1:0];
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		unique case (idx)
			lfpc_pkg::REG_KP:     prdata = 32'(unsigned'(cfg.kp));
			lfpc_pkg::REG_KI:     prdata = 32'(unsigned'(cfg.ki));
			lfpc_pkg::REG_KD:     prdata = 32'(unsigned'(cfg.kd));
			lfpc_pkg::REG_LIMIT:  prdata = 32'(cfg.limit);
			lfpc_pkg::REG_THR:    prdata = 32'(cfg.thr);
			lfpc_pkg::REG_SPU:    prdata = 32'(cfg.spu);
			lfpc_pkg::REG_PERIOD: prdata = 32'(cfg.period);
			lfpc_pkg::REG_RATE:   prdata = 32'(cfg.rate);
		endcase
	end

endmodule

// ===== rtl/lfpc_div.sv =====
// Bit-serial restoring divider: window total over window length.
// One quotient bit per cycle; depends on lfpc_pkg for widths.
`timescale 1ns / 1ps

module lfpc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lfpc_pkg::TOTAL_W-1:0]   dividend,
	input  logic [lfpc_pkg::WIN_W-1:0]     divisor,
	output logic                           done,
	output logic [lfpc_pkg::TOTAL_W-1:0]   quotient
);

	localparam logic [lfpc_pkg::DIV_CNT_W-1:0] LAST =
		lfpc_pkg::DIV_CNT_W'(lfpc_pkg::DIV_STEPS - 1);

	logic                           run_q;
	logic [lfpc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [lfpc_pkg::WIN_W-1:0]     rem_q;
	logic [lfpc_pkg::WIN_W-1:0]     dsr_q;
	logic [lfpc_pkg::TOTAL_W-1:0]   dvd_q;
	logic [lfpc_pkg::WIN_W:0]       trial;
	logic [lfpc_pkg::WIN_W:0]       diff;
	logic                           ge;

	// one restoring step: shift in next dividend bit, try subtract
	assign trial = {rem_q, dvd_q[lfpc_pkg::TOTAL_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	assign done     = run_q && (cnt_q == LAST);
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				run_q <= 1'b0;
			end
		end
	end

	// dividend shifts out the top while quotient bits enter the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[lfpc_pkg::WIN_W-1:0] : trial[lfpc_pkg::WIN_W-1:0];
			dvd_q <= {dvd_q[lfpc_pkg::TOTAL_W-2:0], ge};
		end
	end

endmodule

// ===== rtl/lfpc_mul.sv =====
// Bit-serial signed multiplier: wide operand times a 16-bit gain.
// One gain bit per cycle, shift-right accumulate; depends on lfpc_pkg.
`timescale 1ns / 1ps

module lfpc_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [lfpc_pkg::MCAND_W-1:0]   mcand,
	input  logic signed [lfpc_pkg::GAIN_W-1:0]    mplier,
	output logic                                  done,
	output logic signed [lfpc_pkg::PROD_W-1:0]    product
);

	localparam logic [lfpc_pkg::MUL_CNT_W-1:0] LAST =
		lfpc_pkg::MUL_CNT_W'(lfpc_pkg::MUL_STEPS - 1);

	logic                                 run_q;
	logic [lfpc_pkg::MUL_CNT_W-1:0]       cnt_q;
	logic signed [lfpc_pkg::MCAND_W-1:0]  mc_q;
	logic signed [lfpc_pkg::MCAND_W:0]    hi_q;
	logic [lfpc_pkg::GAIN_W-1:0]          lo_q;
	logic signed [lfpc_pkg::MCAND_W+1:0]  mc_ext;
	logic signed [lfpc_pkg::MCAND_W+1:0]  addend;
	logic signed [lfpc_pkg::MCAND_W+1:0]  sum;

	// gain sign bit has negative weight
	assign mc_ext = (lfpc_pkg::MCAND_W+2)'(mc_q);
	always_comb begin
		if (!lo_q[0]) begin
			addend = '0;
		end else if (cnt_q == LAST) begin
			addend = -mc_ext;
		end else begin
			addend = mc_ext;
		end
	end
	assign sum = (lfpc_pkg::MCAND_W+2)'(hi_q) + addend;

	assign done    = run_q && (cnt_q == LAST);
	assign product = {hi_q[lfpc_pkg::MCAND_W-1:0], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				run_q <= 1'b0;
			end
		end
	end

	// partial product shifts right, low bits drop into the gain register
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (run_q) begin
			hi_q <= sum[lfpc_pkg::MCAND_W+1:1];
			lo_q <= {sum[0], lo_q[lfpc_pkg::GAIN_W-1:1]};
		end
	end

endmodule
